// ===== src/modular_inverse_64_macros.svh =====
// assertion macros for the checker file
// each macro samples on clk_i and is quiet while rst_ni is low
`ifndef MODULAR_INVERSE_64_MACROS_SVH
`define MODULAR_INVERSE_64_MACROS_SVH

// same-cycle implication
`define MI64_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MI64_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/mi64_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi64_pkg
// shared types and constants of the 64-bit modular inverse block
// ----------------------------------------------------------------------------
package mi64_pkg;

  // width of the arithmetic, operands are cut to this many low bits
  localparam int WORD_BITS = 64;
  // fixed width of the value, modulus and inverse ports
  localparam int IO_W      = 64;
  // bit counter of the shared divider
  localparam int CNT_W     = $clog2(WORD_BITS);

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_INVALID        = 2'd1,
    ST_NOT_INVERTIBLE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_CHECK,
    S_STEP,
    S_FOLD,
    S_SIGN,
    S_EMIT
  } state_e;

  // handshake between sequencer and divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ===== src/mi64_divmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi64_divmul
// restoring divider, one quotient bit a cycle, with quotient times mult
// accumulated from the same bits
// ----------------------------------------------------------------------------
module mi64_divmul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mi64_pkg::WORD_BITS-1:0] dividend_i,
  input  logic [mi64_pkg::WORD_BITS-1:0] divisor_i,
  input  logic [mi64_pkg::WORD_BITS-1:0] mult_i,
  output mi64_pkg::div_ctl_t             ctl_o,
  output logic [mi64_pkg::WORD_BITS-1:0] rem_o,
  output logic [mi64_pkg::WORD_BITS-1:0] prod_o
);

  localparam int W = mi64_pkg::WORD_BITS;

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [mi64_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [W-1:0]                 dvd_q, dsr_q, mul_q, rem_q, prod_q;
  logic [W-1:0]                 rem_shift;
  logic [W+1:0]                 diff;
  logic                         qbit;

  // trial subtract of the divisor from the shifted partial remainder
  assign rem_shift = {rem_q[W-2:0], dvd_q[W-1]};
  assign diff      = {1'b0, rem_q, dvd_q[W-1]} - {2'b00, dsr_q};
  assign qbit      = ~diff[W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = mi64_pkg::CNT_W'(W - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      dsr_q  <= divisor_i;
      mul_q  <= mult_i;
      rem_q  <= '0;
      prod_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[W-2:0], 1'b0};
      rem_q  <= qbit ? diff[W-1:0] : rem_shift;
      prod_q <= {prod_q[W-2:0], 1'b0} + (qbit ? mul_q : '0);
    end
  end

  assign ctl_o.busy = busy_q;
  assign ctl_o.done = done_q;
  assign rem_o      = rem_q;
  assign prod_o     = prod_q;

endmodule

// ===== src/modular_inverse_64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_64
// modular inverse of a value by the extended euclidean algorithm
// ----------------------------------------------------------------------------
// One item at a time: the block takes a value and a modulus, reduces the value
// modulo the modulus and runs extended Euclid on the pair, returning the
// inverse in [0, modulus) with status ok, or 0 with status invalid (zero
// modulus) or not invertible (gcd above one). Every division goes through a
// single shared restoring divider that produces one quotient bit per cycle and
// builds quotient times coefficient from the same bits. An item runs one
// division to reduce the value and then one per Euclid step, of which there
// are at most about 93 for 64-bit operands. A zero modulus skips the divider
// and goes from idle straight to the emit state. The input side is
// ready only while the sequencer is idle; a finished item sits in the output
// register while the next item is already being worked on, and the sequencer
// waits at its end only if the previous result has still not been taken.
// ----------------------------------------------------------------------------
module modular_inverse_64 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [mi64_pkg::IO_W-1:0] value_i,
  input  logic [mi64_pkg::IO_W-1:0] modulus_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mi64_pkg::IO_W-1:0] inverse_o,
  output logic [1:0]                status_o
);

  localparam int W = mi64_pkg::WORD_BITS;

  mi64_pkg::state_e   state_q, state_d;
  mi64_pkg::status_e  st_q, st_d;
  mi64_pkg::status_e  status_q;
  mi64_pkg::div_ctl_t div_ctl;

  // euclid registers: remainders r / nr, coefficient magnitudes mt / mnt
  logic [W-1:0] m_q, m_d;
  logic [W-1:0] r_q, r_d;
  logic [W-1:0] nr_q, nr_d;
  logic [W-1:0] mt_q, mt_d;
  logic [W-1:0] mnt_q, mnt_d;
  logic         tneg_q, tneg_d;
  logic [W-1:0] res_q, res_d;
  logic [W-1:0] inverse_q;
  logic         out_valid_q, out_valid_d;

  // shared divider hook-up
  logic         div_start;
  logic [W-1:0] div_dividend, div_divisor, div_mult;
  logic [W-1:0] div_rem, div_prod;

  logic         in_fire;
  logic         emit;
  logic [W-1:0] value_w, modulus_w;

  assign value_w   = value_i[W-1:0];
  assign modulus_w = modulus_i[W-1:0];
  assign in_ready_o = (state_q == mi64_pkg::S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;

  mi64_divmul u_divmul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .mult_i     (div_mult),
    .ctl_o      (div_ctl),
    .rem_o      (div_rem),
    .prod_o     (div_prod)
  );

  // sequencer and datapath next values
  always_comb begin
    state_d      = state_q;
    m_d          = m_q;
    r_d          = r_q;
    nr_d         = nr_q;
    mt_d         = mt_q;
    mnt_d        = mnt_q;
    tneg_d       = tneg_q;
    res_d        = res_q;
    st_d         = st_q;
    emit         = 1'b0;
    div_start    = 1'b0;
    div_dividend = r_q;
    div_divisor  = nr_q;
    div_mult     = mnt_q;

    case (state_q)
      mi64_pkg::S_IDLE: begin
        if (in_fire) begin
          m_d    = modulus_w;
          r_d    = modulus_w;
          mt_d   = '0;
          mnt_d  = W'(1);
          tneg_d = 1'b1;
          if (modulus_w == '0) begin
            res_d   = '0;
            st_d    = mi64_pkg::ST_INVALID;
            state_d = mi64_pkg::S_EMIT;
          end else begin
            // reduce the value first, the product is not used here
            div_start    = 1'b1;
            div_dividend = value_w;
            div_divisor  = modulus_w;
            div_mult     = '0;
            state_d      = mi64_pkg::S_REDUCE;
          end
        end
      end

      mi64_pkg::S_REDUCE: begin
        if (div_ctl.done) begin
          nr_d    = div_rem;
          state_d = mi64_pkg::S_CHECK;
        end
      end

      mi64_pkg::S_CHECK: begin
        if (nr_q == '0) begin
          state_d = mi64_pkg::S_FOLD;
        end else begin
          div_start = 1'b1;
          state_d   = mi64_pkg::S_STEP;
        end
      end

      mi64_pkg::S_STEP: begin
        if (div_ctl.done) begin
          // magnitudes never exceed the modulus, so the sum never wraps
          mt_d    = mnt_q;
          mnt_d   = mt_q + div_prod;
          tneg_d  = ~tneg_q;
          r_d     = nr_q;
          nr_d    = div_rem;
          state_d = mi64_pkg::S_CHECK;
        end
      end

      mi64_pkg::S_FOLD: begin
        if (r_q != W'(1)) begin
          res_d   = '0;
          st_d    = mi64_pkg::ST_NOT_INVERTIBLE;
          state_d = mi64_pkg::S_EMIT;
        end else begin
          // magnitude is at most the modulus, one subtract reduces it
          if (mt_q >= m_q) begin
            mt_d = mt_q - m_q;
          end
          state_d = mi64_pkg::S_SIGN;
        end
      end

      mi64_pkg::S_SIGN: begin
        res_d   = (tneg_q && (mt_q != '0)) ? (m_q - mt_q) : mt_q;
        st_d    = mi64_pkg::ST_OK;
        state_d = mi64_pkg::S_EMIT;
      end

      mi64_pkg::S_EMIT: begin
        // wait only while the previous item is still unclaimed
        if (!out_valid_q || out_ready_i) begin
          emit    = 1'b1;
          state_d = mi64_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = mi64_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_d = emit | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mi64_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    r_q    <= r_d;
    nr_q   <= nr_d;
    mt_q   <= mt_d;
    mnt_q  <= mnt_d;
    tneg_q <= tneg_d;
    res_q  <= res_d;
    st_q   <= st_d;
    if (emit) begin
      inverse_q <= res_q;
      status_q  <= st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign inverse_o   = mi64_pkg::IO_W'(inverse_q);
  assign status_o    = status_q;

endmodule

// ===== src/mi64_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi64_checker
// port-level checks on the modular inverse block, bound to the top level
// ----------------------------------------------------------------------------
`include "modular_inverse_64_macros.svh"

module mi64_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [mi64_pkg::IO_W-1:0] value_i,
  input logic [mi64_pkg::IO_W-1:0] modulus_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [mi64_pkg::IO_W-1:0] inverse_o,
  input logic [1:0]                status_o
);

  logic out_stall;
  logic in_fire;

  assign out_stall = out_valid_o & ~out_ready_i;
  assign in_fire   = in_valid_i & in_ready_o;

  // a stalled item stays up with the same payload
  `MI64_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(inverse_o) && $stable(status_o))

  // the unused status code never shows
  `MI64_ASSERT_NOW(a_status_code, out_valid_o, status_o != 2'd3)

  // any error reports a zero inverse
  `MI64_ASSERT_NOW(a_err_zero, out_valid_o && (status_o != mi64_pkg::ST_OK), inverse_o == '0)

  // one item at a time: intake closes right after an item is taken
  `MI64_ASSERT_NEXT(a_one_item, in_fire, !in_ready_o)

endmodule

bind modular_inverse_64 mi64_checker u_mi64_checker (.*);

// ===== tb/modular_inverse_64_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_64_tb
// self-checking bench for the 64-bit modular inverse block
// ----------------------------------------------------------------------------
// Operand pairs go in through the valid/ready input channel. On acceptance the
// bench works out the expected inverse and status with its own extended
// euclid and queues them. Every result taken from the output channel is
// compared with the oldest queued expectation. The tests run in turn: corner
// operands, then random pairs under four idling mixes, then a long receiver
// hold-off that fills the block, and a pause until every result is back.
// ----------------------------------------------------------------------------
module modular_inverse_64_tb;

  typedef logic [mi64_pkg::IO_W-1:0] word_t;

  typedef struct packed {
    word_t              inverse;
    mi64_pkg::status_e  status;
  } inv_result_t;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 7;
  // cycles with no handshake at all before the run is called hung
  localparam int QUIET_LIMIT  = 40000;
  localparam int HOLD_CYCLES  = 3000;
  // settle time once the last result is back
  localparam int TAIL_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 18;

  // largest prime below 2^64, and two large consecutive fibonacci numbers
  // that push euclid through its longest run of steps
  localparam word_t PRIME_64 = 64'd18446744073709551557;
  localparam word_t FIB_93   = 64'd12200160415121876738;
  localparam word_t FIB_92   = 64'd7540113804746346429;
  localparam word_t ALL_ONES = {mi64_pkg::IO_W{1'b1}};

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  word_t value_i;
  word_t modulus_i;
  logic  out_valid_o;
  logic  out_ready_i;
  word_t inverse_o;
  logic  [1:0] status_o;

  modular_inverse_64 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .modulus_i   (modulus_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .inverse_o   (inverse_o),
    .status_o    (status_o)
  );

  // expected results, oldest first
  inv_result_t pending_inverses_q[$];

  int error_count   = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int count_ok      = 0;
  int count_invalid = 0;
  int count_not_inv = 0;

  // idling mix, in percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // receiver hold-off, counted down by the receiver process
  int hold_left      = 0;
  int quiet_cycles   = 0;

  // clock
  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // extended euclid with the coefficient kept as magnitude plus alternating
  // sign, so nothing grows beyond the word width
  function automatic inv_result_t predict_inverse(word_t value, word_t modulus);
    word_t       mask;
    word_t       a;
    word_t       m;
    word_t       rem_prev;
    word_t       rem_cur;
    word_t       rem_next;
    word_t       quo;
    word_t       coef_prev;
    word_t       coef_cur;
    word_t       coef_next;
    bit          coef_neg;
    inv_result_t res;
    mask = ALL_ONES >> (mi64_pkg::IO_W - mi64_pkg::WORD_BITS);
    a    = value & mask;
    m    = modulus & mask;
    res.inverse = '0;
    if (m == 0) begin
      res.status = mi64_pkg::ST_INVALID;
      return res;
    end
    rem_prev  = m;
    rem_cur   = a % m;
    coef_prev = '0;
    coef_cur  = word_t'(1);
    coef_neg  = 1'b1;
    while (rem_cur != 0) begin
      quo       = rem_prev / rem_cur;
      rem_next  = rem_prev % rem_cur;
      coef_next = (coef_prev + quo * coef_cur) & mask;
      coef_prev = coef_cur;
      coef_cur  = coef_next;
      coef_neg  = ~coef_neg;
      rem_prev  = rem_cur;
      rem_cur   = rem_next;
    end
    if (rem_prev != 1) begin
      res.status = mi64_pkg::ST_NOT_INVERTIBLE;
      return res;
    end
    res.status = mi64_pkg::ST_OK;
    coef_prev  = coef_prev % m;
    // negative coefficient folds back into [0, modulus)
    if (coef_neg && coef_prev != 0) res.inverse = (m - coef_prev) & mask;
    else res.inverse = coef_prev & mask;
    return res;
  endfunction

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH %s", $realtime, what);
    error_count++;
  endtask

  // offers one item; entered and left at a falling edge, valid still high on
  // return so a following item can go out with no gap
  task automatic send_operands(word_t value, word_t modulus);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    modulus_i  <= modulus;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    pending_inverses_q.push_back(predict_inverse(value, modulus));
    items_sent++;
    @(negedge clk_i);
  endtask

  // drops valid, ends on a falling edge
  task automatic release_input();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    while (pending_inverses_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // random operand pair, weighted towards full-width values
  task automatic pick_operands(output word_t value, output word_t modulus);
    int    kind;
    int    factor;
    int    w;
    word_t mask;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3, 4: begin
        value   = rand_word();
        modulus = rand_word();
      end
      5: begin
        // large odd modulus
        value   = rand_word();
        modulus = rand_word() | {1'b1, {(mi64_pkg::IO_W - 2){1'b0}}, 1'b1};
      end
      6: begin
        // shared factor, mostly not invertible
        factor  = $urandom_range(2, 1000);
        value   = (rand_word() >> 24) * word_t'(factor);
        modulus = (rand_word() >> 24) * word_t'(factor);
      end
      7: begin
        // narrow operands of random widths
        w       = $urandom_range(1, mi64_pkg::IO_W);
        mask    = ALL_ONES >> (mi64_pkg::IO_W - w);
        value   = rand_word() & mask;
        w       = $urandom_range(1, mi64_pkg::IO_W);
        mask    = ALL_ONES >> (mi64_pkg::IO_W - w);
        modulus = rand_word() & mask;
      end
      8: begin
        value = rand_word();
        case ($urandom_range(0, 3))
          0: modulus = '0;
          1: modulus = word_t'(1);
          2: begin
            modulus = rand_word();
            value   = '0;
          end
          default: begin
            modulus = (rand_word() >> 32) | word_t'(2);
            value   = modulus * word_t'($urandom_range(1, 1000));
          end
        endcase
      end
      default: begin
        value   = rand_word();
        modulus = PRIME_64;
      end
    endcase
  endtask

  task automatic send_random_items(int n);
    word_t v;
    word_t m;
    repeat (n) begin
      pick_operands(v, m);
      send_operands(v, m);
    end
  endtask

  // receiver: random stalls, or a long hold-off while hold_left runs down
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result checker, field by field against the oldest expectation
  always @(posedge clk_i) begin : check_results
    inv_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_inverses_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: inverse %h status %0d",
                                  inverse_o, status_o));
      end else begin
        want = pending_inverses_q.pop_front();
        results_seen++;
        if (inverse_o !== want.inverse)
          report_mismatch($sformatf("result %0d inverse %h, expected %h",
                                    results_seen, inverse_o, want.inverse));
        if (status_o !== want.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    results_seen, status_o, want.status));
        case (want.status)
          mi64_pkg::ST_OK:      count_ok++;
          mi64_pkg::ST_INVALID: count_invalid++;
          default:              count_not_inv++;
        endcase
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
        $display("modular_inverse_64: mismatch");
        $finish;
      end
    end
  end

  // corner operands: zero and unit moduli, zero values, multiples of the
  // modulus, extreme words, the prime modulus and the longest euclid run
  task automatic test_corner_operands();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_operands('0, '0);
    send_operands(ALL_ONES, '0);
    send_operands(word_t'(5), word_t'(1));
    send_operands('0, word_t'(1));
    send_operands(ALL_ONES, word_t'(1));
    send_operands('0, word_t'(7));
    send_operands(word_t'(21), word_t'(7));
    send_operands(word_t'(3), word_t'(7));
    send_operands(word_t'(1), word_t'(2));
    send_operands(word_t'(6), word_t'(9));
    send_operands(word_t'(10), word_t'(4));
    send_operands(ALL_ONES, ALL_ONES);
    send_operands(ALL_ONES - 1, ALL_ONES);
    send_operands(word_t'(1), ALL_ONES);
    send_operands(word_t'(2), ALL_ONES);
    send_operands(FIB_92, FIB_93);
    send_operands(FIB_93, FIB_92);
    send_operands(word_t'(1) << 63, PRIME_64);
    send_operands(ALL_ONES, PRIME_64);
    send_operands(word_t'(1) << 63, word_t'(1) << 63);
    send_operands(word_t'(3), word_t'(1) << 63);
    send_random_items(RANDOM_ITEMS);
    release_input();
  endtask

  task automatic test_sender_idle();
    send_idle_pct  = 46;
    recv_stall_pct = 0;
    send_random_items(RANDOM_ITEMS);
    release_input();
  endtask

  task automatic test_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    send_random_items(RANDOM_ITEMS);
    release_input();
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 32;
    recv_stall_pct = 32;
    send_random_items(RANDOM_ITEMS);
    release_input();
  endtask

  // long receiver hold-off with short 16-bit items, so one result sits in
  // the output register, the next finishes behind it and the input stalls
  task automatic test_output_hold();
    word_t v;
    word_t m;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    @(negedge clk_i);
    repeat (5) begin
      v = rand_word() & word_t'(16'hffff);
      m = (rand_word() & word_t'(16'hffff)) | word_t'(1);
      send_operands(v, m);
    end
    release_input();
  endtask

  // sender pauses until everything is back, then carries on
  task automatic test_drain_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 20;
    send_random_items(3);
    release_input();
    wait_for_drain();
    send_operands(FIB_92, FIB_93);
    send_operands(word_t'(0), word_t'(0));
    release_input();
  endtask

  initial begin
    // every input set here known from time zero, reset held low
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    value_i    = '0;
    modulus_i  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_corner_operands();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_output_hold();
    test_drain_pause();

    // let everything come back, then a little extra for stray results
    recv_stall_pct = 0;
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d operand pairs, %0d results checked, %0d mismatches",
             items_sent, results_seen, error_count);
    $display("results by status: ok %0d, zero modulus %0d, not invertible %0d",
             count_ok, count_invalid, count_not_inv);
    if (error_count == 0 && pending_inverses_q.size() == 0) begin
      $display("modular_inverse_64: match");
    end else begin
      $display("modular_inverse_64: mismatch");
    end
    $finish;
  end

endmodule
